>>> design/itl_pkg.sv
// Package for the interrupt-table locator scan.
// Holds the payload structs, the scan phase and status codes, and the signature words.
// Has no dependencies; used by itl_ctrl, the top level and the testbench.
package itl_pkg;

    // Input beat: one image word and its end-of-image mark
    typedef struct packed {
        logic [31:0] image_word;
        logic        last_word;
    } itl_in_t;

    // Output beat: scan status and located table address
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] table_address;
    } itl_out_t;

    // Status codes carried in itl_out_t.status
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_START  = 2'd1,
        ST_NO_END    = 2'd2,
        ST_TRUNCATED = 2'd3
    } itl_status_t;

    // Scan phase
    typedef enum logic [1:0] {
        PH_START      = 2'd0,
        PH_END_SEARCH = 2'd1,
        PH_TABLE      = 2'd2,
        PH_RETURN     = 2'd3
    } itl_phase_t;

    // Compare flags from the window cells, bit j from cell j (cell 0 holds the newest word)
    typedef struct packed {
        logic [3:0] start_prev;
        logic [2:0] end_prev;
    } itl_hits_t;

    // Window control from the controller
    typedef struct packed {
        logic shift;
        logic clear;
    } itl_shift_t;

    // Start signature, oldest word first
    localparam logic [31:0] START_PAT [0:4] = '{
        32'he92d4000, 32'he3a0c301, 32'he28cce21, 32'he51c1008, 32'he3510000
    };

    // End signature, oldest word first
    localparam logic [31:0] END_PAT [0:3] = '{
        32'he59f1008, 32'he7910100, 32'he59fe004, 32'he12fff10
    };

endpackage

>>> design/itl_window_cell.sv
// One cell of the word window: holds an earlier image word and compares it
// against its start and end signature words. Depends on nothing but its ports.
module itl_window_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  logic        clear,
    input  logic [31:0] word_in,
    input  logic [31:0] start_pat,
    input  logic [31:0] end_pat,
    output logic [31:0] word_out,
    output logic        start_hit,
    output logic        end_hit
);

    logic [31:0] word_reg;
    logic [31:0] word_next;

    // New scan empties the window
    assign word_next = clear ? '0 : word_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (shift)
        begin
            word_reg <= word_next;
        end
    end

    // Signature compares on the held word
    assign word_out  = word_reg;
    assign start_hit = (word_reg == start_pat);
    assign end_hit   = (word_reg == end_pat);

endmodule

>>> design/itl_ctrl.sv
// Scan controller: phase machine, position and window counters, address arithmetic,
// base register and output register. Depends on itl_pkg and the window cell flags.
module itl_ctrl #(
    parameter int END_WINDOW = 50,
    parameter int MAX_WORDS  = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itl_pkg::itl_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output itl_pkg::itl_out_t  out_data,
    input  logic               cfg_write,
    input  logic [31:0]        cfg_data,
    input  itl_pkg::itl_hits_t hits,
    output itl_pkg::itl_shift_t win_ctl
);

    localparam int POS_W = $clog2(MAX_WORDS);
    localparam int OFF_W = $clog2(END_WINDOW);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(MAX_WORDS - 1);
    localparam logic [POS_W-1:0] POS_START_MIN = POS_W'(4);
    localparam logic [OFF_W-1:0] OFF_FIRST     = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_LAST      = OFF_W'(END_WINDOW - 1);

    itl_pkg::itl_phase_t phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [31:0]         anchor_reg, anchor_next;
    logic [31:0]         table_reg, table_next;
    logic                given_reg;
    logic [31:0]         base_reg;
    logic                out_valid_reg;
    itl_pkg::itl_out_t   out_data_reg;

    logic                accept;
    logic [31:0]         w;
    logic                last_eff;
    logic                start_match;
    logic                end_match;
    logic                emit;
    itl_pkg::itl_status_t status;
    logic [31:0]         addr;

    // Handshake: take a beat whenever the output register is free or draining
    assign in_ready  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign w        = in_data.image_word;
    assign last_eff = in_data.last_word | (pos_reg >= POS_LAST);

    // Signature detection: window cells plus the word in flight
    assign start_match = (&hits.start_prev) && (w == itl_pkg::START_PAT[4])
                         && (pos_reg >= POS_START_MIN);
    assign end_match   = (&hits.end_prev) && (w == itl_pkg::END_PAT[3]);

    assign win_ctl.shift = accept;
    assign win_ctl.clear = last_eff;

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        off_next    = off_reg;
        anchor_next = anchor_reg;
        table_next  = table_reg;
        if (!given_reg)
        begin
            case (phase_reg)
                itl_pkg::PH_START:
                begin
                    if (start_match)
                    begin
                        phase_next = itl_pkg::PH_END_SEARCH;
                        off_next   = OFF_FIRST;
                    end
                end
                itl_pkg::PH_END_SEARCH:
                begin
                    if (end_match)
                    begin
                        phase_next  = itl_pkg::PH_TABLE;
                        // first end word sits at pos-3; table lies 6 words on
                        anchor_next = base_reg + ((32'(pos_reg) + 32'd3) << 2);
                    end
                    else if (off_reg < OFF_LAST)
                    begin
                        off_next = off_reg + OFF_W'(1);
                    end
                end
                itl_pkg::PH_TABLE:
                begin
                    table_next = w;
                    phase_next = itl_pkg::PH_RETURN;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result for the current beat
    always_comb
    begin
        emit   = 1'b0;
        status = itl_pkg::ST_FOUND;
        addr   = '0;
        if (!given_reg)
        begin
            case (phase_reg)
                itl_pkg::PH_END_SEARCH:
                begin
                    if (!end_match && (off_reg >= OFF_LAST))
                    begin
                        emit   = 1'b1;
                        status = itl_pkg::ST_NO_END;
                    end
                end
                itl_pkg::PH_RETURN:
                begin
                    emit   = 1'b1;
                    status = itl_pkg::ST_FOUND;
                    addr   = anchor_reg + ((table_reg - w) & ~32'd3);
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            // image ran out before a decision
            if (!emit && last_eff)
            begin
                emit   = 1'b1;
                status = (phase_next == itl_pkg::PH_START) ? itl_pkg::ST_NO_START
                                                          : itl_pkg::ST_TRUNCATED;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= itl_pkg::PH_START;
            pos_reg   <= '0;
            off_reg   <= '0;
            given_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_eff)
            begin
                phase_reg <= itl_pkg::PH_START;
                pos_reg   <= '0;
                off_reg   <= '0;
                given_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_reg + POS_W'(1);
                off_reg   <= off_next;
                given_reg <= given_reg | emit;
            end
        end
    end

    // Captured addresses
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            anchor_reg <= anchor_next;
            table_reg  <= table_next;
        end
    end

    // Base address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_write)
        begin
            base_reg <= cfg_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg.status        <= status;
            out_data_reg.table_address <= addr;
        end
    end

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && given_reg) |-> !emit)
        else $error("second result in one scan");

    a_last_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_eff && !given_reg) |-> emit)
        else $error("scan ended without a result");

    a_phase_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != itl_pkg::PH_START) |-> (pos_reg > POS_START_MIN))
        else $error("end search entered before a full start signature");

    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == itl_pkg::PH_END_SEARCH) |-> (off_reg >= OFF_FIRST && off_reg <= OFF_LAST))
        else $error("end window offset out of range");

    a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && status == itl_pkg::ST_FOUND) |-> (phase_reg == itl_pkg::PH_RETURN))
        else $error("found reported outside return capture");
`endif

endmodule

>>> design/irq_table_locator_scan_core.sv
// Top level of the interrupt-table locator scan: a chain of four window cells
// and the scan controller. Depends on itl_pkg, itl_window_cell and itl_ctrl.
//
//  channel  | signals                        | beat
//  ---------+--------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data    | one image word, last_word flag
//  output   | out_valid, out_ready, out_data | status and table address
//  config   | cfg_write, cfg_data            | base address write
//
// One image word per cycle while in_ready is high; the result of a beat is registered and
// shows in the cycle after the deciding word. in_ready falls only while a result waits and
// out_ready is low, the single output register being the only buffer.
// Reset clears the window, the phase, counters and the base address.
// A word after last_word, or after MAX_WORDS words, starts a fresh scan.
module irq_table_locator_scan_core #(
    parameter int END_WINDOW = 50,
    parameter int MAX_WORDS  = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  itl_pkg::itl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output itl_pkg::itl_out_t out_data,
    input  logic              cfg_write,
    input  logic [31:0]       cfg_data
);

    itl_pkg::itl_hits_t  hits;
    itl_pkg::itl_shift_t win_ctl;
    logic [31:0]         chain [0:4];

    assign chain[0] = in_data.image_word;

    // Window chain: cell 0 holds the previous word, cell 3 the oldest
    for (genvar j = 0; j < 4; j++)
    begin : g_cell
        if (j < 3)
        begin : g_full
            itl_window_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (win_ctl.shift),
                .clear     (win_ctl.clear),
                .word_in   (chain[j]),
                .start_pat (itl_pkg::START_PAT[3-j]),
                .end_pat   (itl_pkg::END_PAT[2-j]),
                .word_out  (chain[j+1]),
                .start_hit (hits.start_prev[j]),
                .end_hit   (hits.end_prev[j])
            );
        end
        else
        begin : g_oldest
            // oldest word only takes part in the start signature
            itl_window_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (win_ctl.shift),
                .clear     (win_ctl.clear),
                .word_in   (chain[j]),
                .start_pat (itl_pkg::START_PAT[3-j]),
                .end_pat   (itl_pkg::END_PAT[0]),
                .word_out  (chain[j+1]),
                .start_hit (hits.start_prev[j]),
                .end_hit   ()
            );
        end
    end

    // Scan controller
    itl_ctrl #(
        .END_WINDOW (END_WINDOW),
        .MAX_WORDS  (MAX_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .hits      (hits),
        .win_ctl   (win_ctl)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for irq_table_locator_scan_core: a table of directed scans,
// then random code images across several base addresses; results are checked against the table or a predictor.
// Depends on itl_pkg and the design folder; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_WINDOW    = 50;
    localparam int MAX_SCAN_WORDS = 65536;

    // Directed row: beat to send and, where obvious, the result it must close with
    typedef struct packed {
        logic [31:0]          image_word;
        logic                 last_word;
        logic                 checked;
        itl_pkg::itl_status_t status;
        logic [31:0]          table_address;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [0:21] = '{
        // one-word images at the word extremes: no start
        '{32'hffff_ffff, 1'b1, 1'b1, itl_pkg::ST_NO_START, 32'h0},
        '{32'h0000_0000, 1'b1, 1'b1, itl_pkg::ST_NO_START, 32'h0},
        // start cut short by the end of the image
        '{itl_pkg::START_PAT[0], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[1], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[2], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[3], 1'b1, 1'b1, itl_pkg::ST_NO_START, 32'h0},
        // full start on the last word: truncated
        '{itl_pkg::START_PAT[0], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[1], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[2], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[3], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[4], 1'b1, 1'b1, itl_pkg::ST_TRUNCATED, 32'h0},
        // earliest possible match, decided on the last word, address wraps
        '{itl_pkg::START_PAT[0], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[1], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[2], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[3], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::START_PAT[4], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::END_PAT[0], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::END_PAT[1], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::END_PAT[2], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{itl_pkg::END_PAT[3], 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{32'hffff_ffff, 1'b0, 1'b0, itl_pkg::ST_FOUND, 32'h0},
        '{32'h0000_0000, 1'b1, 1'b0, itl_pkg::ST_FOUND, 32'h0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    itl_pkg::itl_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    itl_pkg::itl_out_t out_data;
    logic              cfg_write;
    logic [31:0]       cfg_data;

    // Scan tracker state, mirrors the block
    logic [31:0]         base_reg = '0;
    logic [31:0]         scan_win [0:4] = '{default: '0};
    itl_pkg::itl_phase_t scan_ph = itl_pkg::PH_START;
    logic [16:0]         scan_pos = '0;
    logic [5:0]          end_off = '0;
    logic [16:0]         end_pos = '0;
    logic [31:0]         tbl_word = '0;
    logic                scan_done = 1'b0;

    itl_pkg::itl_out_t pending_results [$];
    int                items_sent = 0;
    int                results_seen = 0;
    int                err_count = 0;
    int                hold_left = 0;

    irq_table_locator_scan_core #(
        .END_WINDOW (SCAN_WINDOW),
        .MAX_WORDS  (MAX_SCAN_WORDS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the tracker by one image word; returns 1 when the scan answers
    function automatic logic locate_step(input logic [31:0] w, input logic lst,
                                         output itl_pkg::itl_out_t res);
        logic                 lst_eff;
        logic                 hit;
        logic                 match;
        itl_pkg::itl_status_t st;
        logic [31:0]          addr;
        lst_eff = lst || (scan_pos >= 17'(MAX_SCAN_WORDS - 1));
        for (int k = 0; k < 4; k++)
            scan_win[k] = scan_win[k + 1];
        scan_win[4] = w;
        hit = 1'b0;
        st = itl_pkg::ST_FOUND;
        addr = '0;
        if (!scan_done)
        begin
            case (scan_ph)
                itl_pkg::PH_START:
                begin
                    match = (scan_pos >= 17'd4);
                    for (int k = 0; k < 5; k++)
                        if (scan_win[k] != itl_pkg::START_PAT[k])
                            match = 1'b0;
                    if (match)
                    begin
                        scan_ph = itl_pkg::PH_END_SEARCH;
                        end_off = 6'd2;
                    end
                end
                itl_pkg::PH_END_SEARCH:
                begin
                    match = 1'b1;
                    for (int k = 0; k < 4; k++)
                        if (scan_win[k + 1] != itl_pkg::END_PAT[k])
                            match = 1'b0;
                    if (match)
                    begin
                        scan_ph = itl_pkg::PH_TABLE;
                        end_pos = scan_pos - 17'd3;
                    end
                    else if (end_off >= 6'(SCAN_WINDOW - 1))
                    begin
                        st = itl_pkg::ST_NO_END;
                        hit = 1'b1;
                    end
                    else
                        end_off = end_off + 6'd1;
                end
                itl_pkg::PH_TABLE:
                begin
                    tbl_word = w;
                    scan_ph = itl_pkg::PH_RETURN;
                end
                default:
                begin
                    st = itl_pkg::ST_FOUND;
                    hit = 1'b1;
                    addr = base_reg + ({15'd0, end_pos} + 32'd6) * 32'd4
                         + ((tbl_word - w) & ~32'd3);
                end
            endcase
            // image over before a decision
            if (!hit && lst_eff)
            begin
                st = (scan_ph == itl_pkg::PH_START) ? itl_pkg::ST_NO_START
                                                    : itl_pkg::ST_TRUNCATED;
                hit = 1'b1;
            end
            if (hit)
                scan_done = 1'b1;
        end
        res.status = st;
        res.table_address = addr;
        if (lst_eff)
        begin
            scan_win = '{default: '0};
            scan_ph = itl_pkg::PH_START;
            scan_pos = '0;
            end_off = '0;
            end_pos = '0;
            tbl_word = '0;
            scan_done = 1'b0;
        end
        else
            scan_pos = scan_pos + 17'd1;
        return hit;
    endfunction

    // Mostly random words, with signature words and extremes mixed in
    function automatic logic [31:0] filler_word();
        case ($urandom_range(0, 9))
            6: return itl_pkg::START_PAT[3'($urandom_range(0, 4))];
            7: return itl_pkg::END_PAT[2'($urandom_range(0, 3))];
            8: return 32'h0;
            9: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat, with random gaps outside the steady stretch
    task automatic send_word(input logic [31:0] w, input logic lst);
        logic took;
        while ((items_sent < 600 || items_sent >= 900) && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{image_word: w, last_word: lst};
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    task automatic push_word(input logic [31:0] w, input logic lst);
        itl_pkg::itl_out_t pred;
        send_word(w, lst);
        if (locate_step(w, lst, pred))
            pending_results.push_back(pred);
    endtask

    // Stop offering and let every outstanding result arrive
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_base(input logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_data <= v;
        base_reg = v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random images: mostly well-formed start/end/capture, some broken or cut short
    task automatic run_scans(input int n_items);
        int          first;
        int          kind;
        int          gap;
        int          cut;
        int          idx;
        logic [31:0] img [$];
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            img.delete();
            kind = $urandom_range(0, 9);
            repeat ($urandom_range(0, 5)) img.push_back(filler_word());
            if (kind != 9)
            begin
                for (int k = 0; k < 5; k++)
                    img.push_back(itl_pkg::START_PAT[k]);
                // one flipped bit in the start signature
                if (kind == 8)
                begin
                    idx = img.size() - 1 - $urandom_range(0, 4);
                    img[idx] = img[idx] ^ (32'h1 << $urandom_range(0, 31));
                end
                // gap around the window limit for the no-end case
                if (kind == 7)
                    gap = $urandom_range(42, 56);
                else if ($urandom_range(0, 3) == 0)
                    gap = $urandom_range(0, 50);
                else
                    gap = $urandom_range(0, 8);
                repeat (gap) img.push_back(filler_word());
                // a near miss on the end signature before the real one
                if (kind == 5)
                begin
                    for (int k = 0; k < 4; k++)
                        img.push_back(itl_pkg::END_PAT[k]);
                    idx = img.size() - 1 - $urandom_range(0, 3);
                    img[idx] = img[idx] ^ (32'h1 << $urandom_range(0, 31));
                    repeat ($urandom_range(0, 3)) img.push_back(filler_word());
                end
                for (int k = 0; k < 4; k++)
                    img.push_back(itl_pkg::END_PAT[k]);
                img.push_back($urandom);
                img.push_back($urandom);
                repeat ($urandom_range(0, 4)) img.push_back(filler_word());
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(1, img.size());
                    while (img.size() > cut)
                        void'(img.pop_back());
                end
            end
            else
                repeat ($urandom_range(1, 20)) img.push_back(filler_word());
            foreach (img[i])
                push_word(img[i], i == img.size() - 1);
        end
    endtask

    // Stimulus
    initial
    begin
        itl_pkg::itl_out_t pred;
        logic              hit;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, base address still at its reset value
        foreach (DIR_ROWS[i])
        begin
            send_word(DIR_ROWS[i].image_word, DIR_ROWS[i].last_word);
            hit = locate_step(DIR_ROWS[i].image_word, DIR_ROWS[i].last_word, pred);
            if (DIR_ROWS[i].checked)
                pending_results.push_back('{status: DIR_ROWS[i].status,
                                            table_address: DIR_ROWS[i].table_address});
            else if (hit)
                pending_results.push_back(pred);
        end
        run_scans(300);
        wait_drained();

        set_base(32'hffff_ffff);
        run_scans(330);
        wait_drained();

        set_base($urandom);
        run_scans(300);
        wait_drained();

        set_base(32'hffff_fffc);
        run_scans(330);
        wait_drained();

        set_base(32'h0);
        run_scans(330);
        wait_drained();

        set_base($urandom);
        run_scans(330);
        wait_drained();

        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Result side: random stalls, one long hold-off, one steady stretch
    initial
    begin
        itl_pkg::itl_out_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (results_seen >= 60 && results_seen < 90)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 9);
            @(negedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 40)
                        $display("%0t: unexpected result, expected none, actual %0d/%h",
                                 $time, out_data.status, out_data.table_address);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.status != out_data.status)
                    begin
                        err_count++;
                        if (err_count <= 40)
                            $display("%0t: status mismatch, expected %0d, actual %0d",
                                     $time, want.status, out_data.status);
                    end
                    if (want.table_address != out_data.table_address)
                    begin
                        err_count++;
                        if (err_count <= 40)
                            $display("%0t: table_address mismatch, expected %h, actual %h",
                                     $time, want.table_address, out_data.table_address);
                    end
                end
                results_seen++;
                // back up the block so that its input stalls
                if (results_seen == 20)
                    hold_left = 80;
            end
        end
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
